@@ hw/rtl/list_insert_ends_delete_value_assert.svh @@
// Assertion macros used by the list block datapath.
`ifndef LIST_INSERT_ENDS_DELETE_VALUE_ASSERT_SVH
`define LIST_INSERT_ENDS_DELETE_VALUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIED_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lied_pkg.sv @@
// Shared types and constants for the bounded list block.
package lied_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        REQ_FRONT  = 2'd0,
        REQ_BACK   = 2'd1,
        REQ_DELETE = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_e_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture request beat
        logic compare;  // register match vector, clear scan index
        logic step;     // advance scan index
        logic push;     // run insert/append/no-op, write result
        logic remove;   // close gap at scan index, write result
        logic miss;     // write not-found result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_delete;
        logic scan_hit;
        logic scan_end;
        logic out_busy;
    } sts_t;

endpackage

@@ hw/rtl/lied_ctrl.sv @@
// Control state machine for the bounded list block.
module lied_ctrl
    import lied_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_SCAN   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.is_delete) begin
                    cmd.compare = 1'b1;
                    state_next  = S_SCAN;
                end else if (!sts.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (sts.scan_hit) begin
                    if (!sts.out_busy) begin
                        cmd.remove = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (sts.scan_end) begin
                    if (!sts.out_busy) begin
                        cmd.miss   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/lied_dp.sv @@
// Datapath: entry cells, length, match vector, scan index and result register.
`include "list_insert_ends_delete_value_assert.svh"
module lied_dp
    import lied_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_item_value,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [1:0]         m_status,
    output logic [4:0]         m_new_length,
    output logic [3:0]         m_removed_position
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    req_e_t             req_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] entries_reg  [CAPACITY];
    logic signed [31:0] entries_next [CAPACITY];
    logic [LW-1:0]      len_reg, len_next;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [IW-1:0]      scan_reg;
    logic               full;
    logic               m_valid_reg;
    status_e_t          status_reg, status_next;
    logic [4:0]         new_len_reg;
    logic [3:0]         pos_reg, pos_next;

    assign full = (len_reg == LW'(CAPACITY));

    assign sts.is_delete = (req_reg == REQ_DELETE);
    assign sts.scan_hit  = match_reg[scan_reg];
    assign sts.scan_end  = ((LW+1)'(scan_reg) + 1'b1) >= (LW+1)'(len_reg);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_next[i] = (entries_reg[i] == val_reg) && (LW'(i) < len_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_next[i] = entries_reg[i];
        end
        len_next    = len_reg;
        status_next = ST_DONE;
        pos_next    = '0;
        if (cmd.push) begin
            case (req_reg)
                REQ_FRONT: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        entries_next[0] = val_reg;
                        for (int i = 1; i < CAPACITY; i++) begin
                            entries_next[i] = entries_reg[i-1];
                        end
                        len_next = len_reg + 1'b1;
                    end
                end
                REQ_BACK: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (LW'(i) == len_reg) begin
                                entries_next[i] = val_reg;
                            end
                        end
                        len_next = len_reg + 1'b1;
                    end
                end
                default: status_next = ST_DONE;
            endcase
        end else if (cmd.remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IW'(i) >= scan_reg) begin
                    entries_next[i] = entries_reg[i+1];
                end
            end
            len_next = len_reg - 1'b1;
            pos_next = 4'(scan_reg);
        end else if (cmd.miss) begin
            status_next = ST_NOT_FOUND;
        end
    end

    // Entry cells, request payload, match vector, scan index and result fields hold no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_reg[i] <= entries_next[i];
        end
        if (cmd.load) begin
            req_reg <= req_e_t'(s_req_type);
            val_reg <= s_item_value;
        end
        if (cmd.compare) begin
            match_reg <= match_next;
        end
        if (cmd.compare) begin
            scan_reg <= '0;
        end else if (cmd.step) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.push || cmd.remove || cmd.miss) begin
            status_reg  <= status_next;
            new_len_reg <= 5'(len_next);
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (cmd.push || cmd.remove || cmd.miss) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_new_length       = new_len_reg;
    assign m_removed_position = pos_reg;

    `LIED_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LW'(CAPACITY), "length above capacity")
    `LIED_ASSERT_NOW(a_result_slot_free, aclk, aresetn, cmd.push || cmd.remove || cmd.miss, !sts.out_busy, "result written over a pending beat")
    `LIED_ASSERT_NEXT(a_remove_shrinks, aclk, aresetn, cmd.remove, (len_reg == $past(len_reg) - 1'b1) && m_valid_reg, "delete did not shrink list")
    `LIED_ASSERT_NOW(a_miss_no_match, aclk, aresetn, cmd.miss, match_reg == '0, "not-found reported with a match present")

endmodule

@@ hw/rtl/list_insert_ends_delete_value.sv @@
// Insert or append: the beat is captured in S_IDLE and executed in S_DECODE, which writes the
// result register. Delete: S_DECODE registers the match vector, then S_SCAN walks it one bit per
// cycle to the first match (to length-1 on a miss, 0 on an empty list) and writes the result.
// A new input beat is taken only in S_IDLE; the controller holds in S_DECODE or S_SCAN while the
// previous result still waits. Reset (aresetn, synchronous, active low) empties the list and drops
// any pending result; the entry cells themselves are not cleared.
module list_insert_ends_delete_value
    import lied_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [4:0]         m_new_length,
    output logic [3:0]         m_removed_position
);

    // Controller drives the datapath through one command group and reads back
    // one status group: request kind, scan hit/end and output-slot busy.
    cmd_t cmd;
    sts_t sts;

    lied_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath holds the cells, the length and the result register; the result
    // register decouples the output beat so a new request can be taken while it waits.
    lied_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_req_type         (s_req_type),
        .s_item_value       (s_item_value),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_status           (m_status),
        .m_new_length       (m_new_length),
        .m_removed_position (m_removed_position)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the bounded list block: push front, push back, delete first match.
module tb;
    import lied_pkg::*;

    // The block has no request code 3; it must act as a no-op.
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam int CAP            = CAPACITY_DEF;
    // A delete scans at most CAP entries, one per cycle.
    localparam int DRAIN_CYCLES   = CAP + 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 800;
    localparam int LIMIT_CYCLES   = 400000;

    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_TAIL = 32'h5A5A_5A5A;

    typedef struct {
        logic [1:0] status;
        logic [4:0] new_length;
        logic [3:0] removed_position;
    } list_result_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type   = REQ_FRONT;
    logic signed [31:0] s_item_value = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [1:0]         m_status;
    logic [4:0]         m_new_length;
    logic [3:0]         m_removed_position;

    // Shadow copy of the list, updated at each accepted request beat.
    logic [31:0]  shadow_list [CAP];
    int           shadow_len = 0;
    list_result_t pending_results[$];
    int           err_count  = 0;
    bit           rx_hold    = 1'b0;

    list_insert_ends_delete_value #(
        .CAPACITY(CAP)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_item_value      (s_item_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_new_length      (m_new_length),
        .m_removed_position(m_removed_position)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it must produce.
    function automatic list_result_t apply_request(input logic [1:0] req, input logic [31:0] val);
        list_result_t r;
        int hit;
        r.status           = ST_DONE;
        r.removed_position = '0;
        hit                = -1;
        case (req)
            REQ_FRONT, REQ_BACK: begin
                if (shadow_len >= CAP) begin
                    // Full list: refuse the push, leave everything as is.
                    r.status = ST_FULL;
                end else if (req == REQ_FRONT) begin
                    for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[0] = val;
                    shadow_len++;
                end else begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            end
            REQ_DELETE: begin
                // Lowest index wins when the value is held more than once.
                for (int i = 0; i < shadow_len; i++) begin
                    if (hit < 0 && shadow_list[i] == val) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                    r.removed_position = 4'(hit);
                end
            end
            default: ;
        endcase
        r.new_length = 5'(shadow_len);
        return r;
    endfunction

    // Predict on every accepted request beat, then check every accepted result beat
    // against the oldest prediction. Both sample the values present just before the edge.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && s_valid && s_ready) begin
            pending_results.insert(pending_results.size(),
                                   apply_request(s_req_type, s_item_value));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request waiting: status %0d length %0d pos %0d",
                       m_status, m_new_length, m_removed_position);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    err_count++;
                end
                if (m_new_length !== want.new_length) begin
                    $error("new_length: expected %0d, got %0d", want.new_length, m_new_length);
                    err_count++;
                end
                if (m_removed_position !== want.removed_position) begin
                    $error("removed_position: expected %0d, got %0d",
                           want.removed_position, m_removed_position);
                    err_count++;
                end
            end
        end
    end

    // Result-side backpressure: switch between randomly chosen stall patterns,
    // and hold ready low for a long stretch whenever a test asks for it.
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
                rx_hold = 1'b0;
                m_ready <= 1'b1;
                left = 0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (left % 5 != 0);
                endcase
            end
        end
    end

    // Drive one request beat at the current falling edge and hold it until accepted.
    task automatic offer_beat(input logic [1:0] req, input logic [31:0] val);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_item_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_item(input logic [1:0] req, input logic [31:0] val);
        @(negedge aclk);
        offer_beat(req, val);
    endtask

    // Pick a request once the shadow list has caught up with the last accepted beat.
    // Growing phases favor pushes, shrinking phases favor deletes of held values.
    task automatic send_random(input bit grow, output logic [1:0] req);
        logic [31:0] val;
        int roll;
        @(negedge aclk);
        roll = $urandom_range(0, 99);
        if (roll < 4) req = REQ_NOP;
        else if (roll < (grow ? 70 : 30)) req = $urandom_range(0, 1) ? REQ_FRONT : REQ_BACK;
        else req = REQ_DELETE;
        if (req == REQ_DELETE && shadow_len > 0 && $urandom_range(0, 3) != 0) begin
            val = shadow_list[$urandom_range(0, shadow_len - 1)];
        end else begin
            case ($urandom_range(0, 9))
                0:       val = VAL_MIN;
                1:       val = VAL_MAX;
                // Small values make duplicates, so first-match deletes get exercised.
                2, 3, 4: val = 32'(int'($urandom_range(0, 8)) - 4);
                default: val = $urandom;
            endcase
        end
        offer_beat(req, val);
    endtask

    // Drop valid and idle the sender for a gap set by n; scramble the payload while idle.
    task automatic sender_gap(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid      <= 1'b0;
            s_item_value <= $urandom;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Idle the sender until every predicted result has come, then let the block settle.
    task automatic wait_drained();
        sender_gap(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_empty_list();
        send_item(REQ_DELETE, 32'h0000_0000);
        send_item(REQ_NOP, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Leaves the list as [-1, MIN, 0].
    task automatic test_ends_and_extremes();
        send_item(REQ_FRONT, VAL_MIN);
        send_item(REQ_BACK, VAL_MAX);
        send_item(REQ_FRONT, 32'hFFFF_FFFF);
        send_item(REQ_BACK, 32'h0000_0000);
        send_item(REQ_DELETE, VAL_MAX);
        send_item(REQ_DELETE, 32'h0000_3039);
        wait_drained();
    endtask

    task automatic test_full_list();
        for (int k = 0; k < 12; k++) send_item((k % 2) ? REQ_BACK : REQ_FRONT, 32'd7);
        send_item(REQ_BACK, VAL_TAIL);
        // Pushes onto the full list are refused; the no-op leaves it full.
        send_item(REQ_FRONT, 32'd1);
        send_item(REQ_BACK, 32'd2);
        send_item(REQ_NOP, 32'd3);
        // Remove the very last entry, then the first of many duplicates.
        send_item(REQ_DELETE, VAL_TAIL);
        send_item(REQ_DELETE, 32'd7);
        wait_drained();
    endtask

    // Stall the result side for a long stretch while offering beats back to back,
    // so the block fills up and drops s_ready.
    task automatic test_receiver_holdoff();
        logic [1:0] req;
        rx_hold = 1'b1;
        for (int k = 0; k < 24; k++) send_random(1'b1, req);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [1:0] req;
        int sent;
        int burst;
        bit grow;
        sent = 0;
        grow = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_random(grow, req);
                if (req != REQ_NOP) begin
                    sent++;
                    // Flip the drift often enough to reach both full and empty.
                    if (sent % 48 == 0) grow = !grow;
                    if (sent % 200 == 0) wait_drained();
                end
            end
            if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 10));
        end
    endtask

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_ends_and_extremes();
        test_full_list();
        test_receiver_holdoff();
        test_random_traffic();
        wait_drained();
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
